/* rtl/core/qts_pkg.sv */
package qts_pkg;

  localparam int UNIT_BITS = 16;
  localparam int QDEPTH = 4;
  localparam int PTR_BITS = $clog2(QDEPTH);
  localparam int CNT_BITS = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_UNIT = 2'd0,
    KIND_DONE = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [UNIT_BITS-1:0] unit;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } parse_t;

endpackage

/* rtl/core/quoted_token_splitter_core.sv */
// A code word accepted into the input stage is parsed when the result queue has room, and its
// results are written into the result queue, whose head word is then offered.
// Throughput: one code word per cycle while the 4-entry result queue has room for two more
// results; a word that yields two results writes both at once, and input stalls when short of room.
// Reset: rst (synchronous, active high) empties the input stage and result queue
// and returns the parser to skipping whitespace.
module quoted_token_splitter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          code_valid,
  output logic                          code_ready,
  input  logic [qts_pkg::UNIT_BITS-1:0] code_unit,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [1:0]                    kind,
  output logic [qts_pkg::UNIT_BITS-1:0] out_unit
);

  logic                          stage_valid;
  logic [qts_pkg::UNIT_BITS-1:0] stage_unit;
  logic                          room;
  logic                          step;
  logic                          pop;

  qts_pkg::parse_t  res;
  qts_pkg::parse_t  push;
  qts_pkg::result_t head;

  assign step       = stage_valid && room;
  assign code_ready = !stage_valid || room;
  assign pop        = result_valid && result_ready;

  always_comb begin
    push = res;
    if (!step) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (code_valid && code_ready) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (code_valid && code_ready) begin
      stage_unit <= code_unit;
    end
  end

  qts_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .unit (stage_unit),
    .res  (res)
  );

  qts_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .room      (room),
    .not_empty (result_valid),
    .head      (head)
  );

  assign kind     = head.kind;
  assign out_unit = head.unit;

endmodule

/* rtl/core/qts_parse.sv */
module qts_parse (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [qts_pkg::UNIT_BITS-1:0]  unit,
  output qts_pkg::parse_t                res
);

  typedef enum logic [1:0] {
    MODE_SKIP   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_HELD   = 2'd3
  } mode_t;

  localparam logic [qts_pkg::UNIT_BITS-1:0] CH_SPACE  = qts_pkg::UNIT_BITS'(8'h20);
  localparam logic [qts_pkg::UNIT_BITS-1:0] CH_TAB    = qts_pkg::UNIT_BITS'(8'h09);
  localparam logic [qts_pkg::UNIT_BITS-1:0] CH_CR     = qts_pkg::UNIT_BITS'(8'h0D);
  localparam logic [qts_pkg::UNIT_BITS-1:0] CH_LF     = qts_pkg::UNIT_BITS'(8'h0A);
  localparam logic [qts_pkg::UNIT_BITS-1:0] CH_QUOTE  = qts_pkg::UNIT_BITS'(8'h22);
  localparam logic [qts_pkg::UNIT_BITS-1:0] CH_BSLASH = qts_pkg::UNIT_BITS'(8'h5C);
  localparam logic [qts_pkg::UNIT_BITS-1:0] ZERO      = '0;

  mode_t mode;
  mode_t mode_next;
  logic  is_end;
  logic  is_space;

  qts_pkg::result_t r_unit;
  qts_pkg::result_t r_bslash;
  qts_pkg::result_t r_quote;
  qts_pkg::result_t r_done;
  qts_pkg::result_t r_none;

  assign is_end   = (unit == ZERO);
  assign is_space = (unit == CH_SPACE) || (unit == CH_TAB) || (unit == CH_CR) ||
                    (unit == CH_LF);

  assign r_unit   = '{kind: qts_pkg::KIND_UNIT, unit: unit};
  assign r_bslash = '{kind: qts_pkg::KIND_UNIT, unit: CH_BSLASH};
  assign r_quote  = '{kind: qts_pkg::KIND_UNIT, unit: CH_QUOTE};
  assign r_done   = '{kind: qts_pkg::KIND_DONE, unit: ZERO};
  assign r_none   = '{kind: qts_pkg::KIND_NONE, unit: ZERO};

  always_comb begin
    res       = '{count: 2'd0, first: r_done, second: r_done};
    mode_next = mode;
    unique case (mode)
      MODE_SKIP: begin
        if (is_end) begin
          res.count = 2'd1;
          res.first = r_none;
        end else if (is_space) begin
          mode_next = MODE_SKIP;
        end else if (unit == CH_QUOTE) begin
          mode_next = MODE_QUOTED;
        end else begin
          res.count = 2'd1;
          res.first = r_unit;
          mode_next = MODE_PLAIN;
        end
      end
      MODE_PLAIN: begin
        res.count = 2'd1;
        if (is_end || is_space) begin
          res.first = r_done;
          mode_next = MODE_SKIP;
        end else begin
          res.first = r_unit;
        end
      end
      MODE_QUOTED: begin
        if (is_end || unit == CH_QUOTE) begin
          res.count = 2'd1;
          res.first = r_done;
          mode_next = MODE_SKIP;
        end else if (unit == CH_BSLASH) begin
          mode_next = MODE_HELD;
        end else begin
          res.count = 2'd1;
          res.first = r_unit;
        end
      end
      MODE_HELD: begin
        if (unit == CH_QUOTE) begin
          res.count = 2'd1;
          res.first = r_quote;
          mode_next = MODE_QUOTED;
        end else if (unit == CH_BSLASH) begin
          res.count = 2'd1;
          res.first = r_bslash;
        end else if (is_end) begin
          res.count  = 2'd2;
          res.first  = r_bslash;
          res.second = r_done;
          mode_next  = MODE_SKIP;
        end else begin
          res.count  = 2'd2;
          res.first  = r_bslash;
          res.second = r_unit;
          mode_next  = MODE_QUOTED;
        end
      end
      default: begin
        mode_next = MODE_SKIP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SKIP;
    end else if (step) begin
      mode <= mode_next;
    end
  end

endmodule

/* rtl/core/qts_fifo.sv */
module qts_fifo (
  input  logic             clk,
  input  logic             rst,
  input  qts_pkg::parse_t  push,
  input  logic             pop,
  output logic             room,
  output logic             not_empty,
  output qts_pkg::result_t head
);

  qts_pkg::result_t mem [qts_pkg::QDEPTH];

  logic [qts_pkg::PTR_BITS-1:0] wr_ptr;
  logic [qts_pkg::PTR_BITS-1:0] wr_ptr_plus;
  logic [qts_pkg::PTR_BITS-1:0] rd_ptr;
  logic [qts_pkg::CNT_BITS-1:0] count;
  logic [qts_pkg::CNT_BITS-1:0] count_next;

  assign wr_ptr_plus = wr_ptr + qts_pkg::PTR_BITS'(1);
  assign count_next  = count + qts_pkg::CNT_BITS'(push.count) - qts_pkg::CNT_BITS'(pop);
  assign room        = (count <= qts_pkg::CNT_BITS'(qts_pkg::QDEPTH - 2));
  assign not_empty   = (count != '0);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_plus] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + qts_pkg::PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + qts_pkg::PTR_BITS'(pop);
      count  <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= qts_pkg::CNT_BITS'(qts_pkg::QDEPTH))
    else $error("result queue count out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |->
      ((qts_pkg::CNT_BITS+1)'(count) + (qts_pkg::CNT_BITS+1)'(push.count) <=
       (qts_pkg::CNT_BITS+1)'(qts_pkg::QDEPTH)))
    else $error("result queue overrun");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("result queue underrun");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (!not_empty && push.count != 2'd0) |=> not_empty)
    else $error("pushed word not presented");
`endif

endmodule

/* dv/quoted_token_splitter_core_tb.sv */
`timescale 1ns / 1ps

module quoted_token_splitter_core_tb;

  localparam logic [15:0] CH_NUL = 16'h0000;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_TAB = 16'h0009;
  localparam logic [15:0] CH_CR = 16'h000D;
  localparam logic [15:0] CH_LF = 16'h000A;
  localparam logic [15:0] CH_QUOTE = 16'h0022;
  localparam logic [15:0] CH_BSLASH = 16'h005C;
  localparam int RANDOM_UNITS = 1850;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef enum logic [1:0] {
    MODE_SKIP   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_HELD   = 2'd3
  } parse_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          code_valid = 1'b0;
  logic                          code_ready;
  logic [qts_pkg::UNIT_BITS-1:0] code_unit = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  logic [1:0]                    kind;
  logic [qts_pkg::UNIT_BITS-1:0] out_unit;

  logic [15:0]      text_units_q[$];
  qts_pkg::result_t token_words_q[$];
  parse_mode_t      parse_mode = MODE_SKIP;

  int  errors = 0;
  int  units_taken = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  send_phase_left = 0;
  bit  send_idle = 1'b0;
  int  recv_stall = 0;
  int  recv_phase_left = 0;
  bit  recv_idle = 1'b0;
  int  hold_off = 0;
  bit  hold_off_done = 1'b0;
  int  directed_units;

  quoted_token_splitter_core dut (
    .clk          (clk),
    .rst          (rst),
    .code_valid   (code_valid),
    .code_ready   (code_ready),
    .code_unit    (code_unit),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .out_unit     (out_unit)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit is_blank(logic [15:0] u);
    return u == CH_SPACE || u == CH_TAB || u == CH_CR || u == CH_LF;
  endfunction

  function automatic void push_word(qts_pkg::kind_t k, logic [15:0] u);
    qts_pkg::result_t w;
    w.kind = k;
    w.unit = (k == qts_pkg::KIND_UNIT) ? u : '0;
    token_words_q.push_back(w);
  endfunction

  function automatic void tokenize_unit(logic [15:0] u);
    case (parse_mode)
      MODE_SKIP: begin
        if (u == CH_NUL) begin
          push_word(qts_pkg::KIND_NONE, '0);
        end else if (u == CH_QUOTE) begin
          parse_mode = MODE_QUOTED;
        end else if (!is_blank(u)) begin
          push_word(qts_pkg::KIND_UNIT, u);
          parse_mode = MODE_PLAIN;
        end
      end
      MODE_PLAIN: begin
        if (u == CH_NUL || is_blank(u)) begin
          push_word(qts_pkg::KIND_DONE, '0);
          parse_mode = MODE_SKIP;
        end else begin
          push_word(qts_pkg::KIND_UNIT, u);
        end
      end
      MODE_QUOTED: begin
        if (u == CH_NUL || u == CH_QUOTE) begin
          push_word(qts_pkg::KIND_DONE, '0);
          parse_mode = MODE_SKIP;
        end else if (u == CH_BSLASH) begin
          parse_mode = MODE_HELD;
        end else begin
          push_word(qts_pkg::KIND_UNIT, u);
        end
      end
      default: begin
        if (u == CH_QUOTE) begin
          push_word(qts_pkg::KIND_UNIT, CH_QUOTE);
          parse_mode = MODE_QUOTED;
        end else if (u == CH_BSLASH) begin
          push_word(qts_pkg::KIND_UNIT, CH_BSLASH);
        end else if (u == CH_NUL) begin
          push_word(qts_pkg::KIND_UNIT, CH_BSLASH);
          push_word(qts_pkg::KIND_DONE, '0);
          parse_mode = MODE_SKIP;
        end else begin
          push_word(qts_pkg::KIND_UNIT, CH_BSLASH);
          push_word(qts_pkg::KIND_UNIT, u);
          parse_mode = MODE_QUOTED;
        end
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // special character in the low byte, nonzero high byte
  function automatic logic [15:0] pick_alias();
    logic [7:0] hi;
    logic [7:0] lo;
    hi = 8'($urandom_range(1, 255));
    case ($urandom_range(0, 6))
      0: lo = CH_SPACE[7:0];
      1: lo = CH_TAB[7:0];
      2: lo = CH_CR[7:0];
      3: lo = CH_LF[7:0];
      4: lo = CH_QUOTE[7:0];
      5: lo = CH_BSLASH[7:0];
      default: lo = CH_NUL[7:0];
    endcase
    return {hi, lo};
  endfunction

  function automatic logic [15:0] pick_token_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($urandom_range(16'h21, 16'h7E));
    if (r < 80) return 16'($urandom_range(1, 16'hFFFF));
    return pick_alias();
  endfunction

  function automatic logic [15:0] pick_noise_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return pick_blank();
    if (r < 30) return CH_QUOTE;
    if (r < 45) return CH_BSLASH;
    if (r < 53) return CH_NUL;
    if (r < 70) return pick_alias();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic add_quoted_token(int len);
    text_units_q.push_back(CH_QUOTE);
    repeat (len) begin
      if ($urandom_range(0, 99) < 15) begin
        text_units_q.push_back(CH_BSLASH);
        case ($urandom_range(0, 2))
          0: text_units_q.push_back(CH_QUOTE);
          1: text_units_q.push_back(CH_BSLASH);
          default: text_units_q.push_back(pick_token_unit());
        endcase
      end else begin
        text_units_q.push_back(pick_token_unit());
      end
    end
    if ($urandom_range(0, 9) != 0) text_units_q.push_back(CH_QUOTE);
  endtask

  task automatic add_text();
    int ntok;
    int len;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) text_units_q.push_back(pick_noise_unit());
      if ($urandom_range(0, 1) != 0) text_units_q.push_back(CH_NUL);
    end else begin
      repeat ($urandom_range(0, 2)) text_units_q.push_back(pick_blank());
      ntok = $urandom_range(0, 4);
      for (int i = 0; i < ntok; i++) begin
        if (i > 0) repeat ($urandom_range(1, 2)) text_units_q.push_back(pick_blank());
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 6);
        if ($urandom_range(0, 9) < 4) begin
          add_quoted_token(len);
        end else begin
          repeat ((len == 0) ? 1 : len) text_units_q.push_back(pick_token_unit());
        end
      end
      if ($urandom_range(0, 3) == 0) text_units_q.push_back(pick_blank());
      text_units_q.push_back(CH_NUL);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
      code_unit <= '0;
      send_gap <= 0;
    end else begin
      if (code_valid && code_ready) begin
        tokenize_unit(code_unit);
        units_taken <= units_taken + 1;
      end
      if (!code_valid || code_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          code_valid <= 1'b0;
        end else if (text_units_q.size() != 0) begin
          code_valid <= 1'b1;
          code_unit <= text_units_q.pop_front();
          if (send_phase_left == 0) begin
            send_phase_left <= $urandom_range(50, 300);
            send_idle <= ($urandom_range(0, 9) < 7);
          end else begin
            send_phase_left <= send_phase_left - 1;
          end
          if (send_idle && $urandom_range(0, 99) < 30) send_gap <= pick_gap();
        end else begin
          code_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      result_ready <= 1'b0;
    end else if (!hold_off_done && units_taken >= 300) begin
      hold_off <= HOLD_OFF_CYCLES;
      hold_off_done <= 1'b1;
      result_ready <= 1'b0;
    end else begin
      if (recv_phase_left == 0) begin
        recv_phase_left <= $urandom_range(50, 300);
        recv_idle <= ($urandom_range(0, 9) < 7);
      end else begin
        recv_phase_left <= recv_phase_left - 1;
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        result_ready <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 99) < 25) begin
        recv_stall <= pick_gap();
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_words
    qts_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (token_words_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind=%0d unit=%h",
                 $time, kind, out_unit);
        errors++;
      end else begin
        want = token_words_q.pop_front();
        if (kind !== want.kind || out_unit !== want.unit) begin
          $display("%0t: mismatch, expected kind=%0d unit=%h, actual kind=%0d unit=%h",
                   $time, want.kind, want.unit, kind, out_unit);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (code_valid && code_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    // empty texts, blanks only
    text_units_q.push_back(CH_NUL);
    text_units_q.push_back(CH_SPACE);
    text_units_q.push_back(CH_TAB);
    text_units_q.push_back(CH_CR);
    text_units_q.push_back(CH_LF);
    text_units_q.push_back(CH_NUL);
    // plain token with extreme and look-alike units
    text_units_q.push_back(16'hFFFF);
    text_units_q.push_back(16'h0120);
    text_units_q.push_back(CH_SPACE);
    // quoted token: escaped quote, backslash runs, kept backslash
    text_units_q.push_back(CH_QUOTE);
    text_units_q.push_back(CH_BSLASH);
    text_units_q.push_back(CH_QUOTE);
    text_units_q.push_back(CH_BSLASH);
    text_units_q.push_back(CH_BSLASH);
    text_units_q.push_back(CH_BSLASH);
    text_units_q.push_back(16'h0061);
    text_units_q.push_back(16'h8000);
    text_units_q.push_back(CH_QUOTE);
    // empty quoted token
    text_units_q.push_back(CH_QUOTE);
    text_units_q.push_back(CH_QUOTE);
    // text right after a closing quote, plain token ended by end of text
    text_units_q.push_back(CH_QUOTE);
    text_units_q.push_back(16'h0122);
    text_units_q.push_back(CH_QUOTE);
    text_units_q.push_back(16'h007A);
    text_units_q.push_back(CH_NUL);
    // held backslash at end of text
    text_units_q.push_back(CH_QUOTE);
    text_units_q.push_back(CH_BSLASH);
    text_units_q.push_back(CH_NUL);
    directed_units = text_units_q.size();
    while (text_units_q.size() < directed_units + RANDOM_UNITS) add_text();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (text_units_q.size() != 0 || code_valid) @(posedge clk);
    while (token_words_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/qts_pkg.sv
rtl/core/qts_parse.sv
rtl/core/qts_fifo.sv
rtl/core/quoted_token_splitter_core.sv
dv/quoted_token_splitter_core_tb.sv
